FILE: rtl/core/sorted_priority_queue_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue unit
// Overlapping-implication and next-cycle-implication checks, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SPQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spq: assertion failed");

// Check that cons holds in the cycle after ante.
`define SPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq: assertion failed");

`endif

FILE: rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, action and status codes, and types shared across the unit.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_WIDTH  = 16;
  localparam int PRIO_WIDTH  = 8;
  localparam int POS_WIDTH   = 4;
  localparam int OCC_WIDTH   = 5;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ACT_INSERT      = 2'd0;
  localparam logic [1:0] ACT_REMOVE_HEAD = 2'd1;
  localparam logic [1:0] ACT_REMOVE_AT   = 2'd2;
  localparam logic [1:0] ACT_COUNT       = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] data;
    logic [PRIO_WIDTH-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

endpackage

FILE: rtl/core/spq_if.sv
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_in_if;
  import spq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [DATA_WIDTH-1:0] payload_in;
  logic [PRIO_WIDTH-1:0] priority_req;
  logic [POS_WIDTH-1:0]  position;

  modport source (output valid, action, payload_in, priority_req, position, input ready);
  modport sink   (input valid, action, payload_in, priority_req, position, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] payload_out;
  logic                  payload_valid;
  logic [OCC_WIDTH-1:0]  occupancy;
  logic [1:0]            status;

  modport source (output valid, payload_out, payload_valid, occupancy, status, input ready);
  modport sink   (input valid, payload_out, payload_valid, occupancy, status, output ready);
endinterface

FILE: rtl/core/sorted_priority_queue_unit.sv
// Count, full, empty and out-of-range items give a registered result in the cycle after acceptance.
// Insert: one stored entry compared and moved per cycle, from the tail towards the head.
// Remove at position p: one entry moved up per cycle, from p + 1 to the tail.
// One item at a time: a new item is taken only while idle, once the last result is taken or being taken.
// Reset: entry count cleared at once, store contents left undefined, no clearing pass.
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded queue held in descending priority order, newest first among ties.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    req_i,
  spq_out_if.source rsp_o
);
  import spq_pkg::*;

  // Store request from the sequencer and the registered read entry back.
  mem_req_t mem_req;
  entry_t   mem_rdata;

  // The sequencer owns the handshake and result register; hold the result
  // until taken, and stay not-ready while an insert scan or removal shift runs.
  spq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .mem_req_o (mem_req),
    .rdata_i   (mem_rdata)
  );

  // Entries sit head first at index zero; only entries below the occupancy
  // are ever read.
  spq_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

FILE: rtl/core/spq_store.sv
// ----------------------------------------------------------------------------
// Sorted priority queue entry store
// One write port and one registered read port over the queue entries.
// ----------------------------------------------------------------------------
module spq_store (
  input  logic              clk_i,
  input  spq_pkg::mem_req_t req_i,
  output spq_pkg::entry_t   rdata_o
);
  import spq_pkg::*;

  entry_t mem_q [QUEUE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/spq_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted priority queue sequencer
// Walks the store one entry a cycle through a single compare and move step.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_unit_defines.svh"

module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  spq_in_if.sink            req_i,
  spq_out_if.source         rsp_o,
  output spq_pkg::mem_req_t mem_req_o,
  input  spq_pkg::entry_t   rdata_i
);
  import spq_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS     = 3'd1;
  localparam logic [2:0] S_INSHEAD = 3'd2;
  localparam logic [2:0] S_TAKE    = 3'd3;
  localparam logic [2:0] S_SHIFT   = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      k_q, k_d;
  entry_t                new_q, new_d;
  logic [DATA_WIDTH-1:0] taken_q, taken_d;

  logic                  ov_q;
  logic [DATA_WIDTH-1:0] res_data_q, res_data_d;
  logic                  pv_q, res_pv_d;
  logic [1:0]            status_q, res_status_d;
  logic [OCC_WIDTH-1:0]  occ_q;
  logic                  res_load;

  logic                  accept;
  logic [POS_WIDTH-1:0]  pos;
  logic                  more;

  assign req_i.ready = (state_q == S_IDLE) && (!ov_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign pos         = (req_i.action == ACT_REMOVE_HEAD) ? '0 : req_i.position;
  assign more        = (CNT_W'(k_q) + 1'b1) < count_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    k_d          = k_q;
    new_d        = new_q;
    taken_d      = taken_q;
    mem_req_o    = '0;
    res_load     = 1'b0;
    res_data_d   = '0;
    res_pv_d     = 1'b0;
    res_status_d = ST_OK;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (req_i.action)
            ACT_INSERT: begin
              new_d.data = req_i.payload_in;
              new_d.prio = req_i.priority_req;
              if (count_q == CNT_W'(QUEUE_DEPTH)) begin
                res_load     = 1'b1;
                res_status_d = ST_FULL;
              end else if (count_q == '0) begin
                mem_req_o.wr_en   = 1'b1;
                mem_req_o.wr_addr = '0;
                mem_req_o.wr_data = new_d;
                count_d           = CNT_W'(1);
                res_load          = 1'b1;
              end else begin
                mem_req_o.rd_en   = 1'b1;
                mem_req_o.rd_addr = IDX_W'(count_q - 1'b1);
                k_d               = IDX_W'(count_q - 1'b1);
                state_d           = S_INS;
              end
            end
            ACT_REMOVE_HEAD, ACT_REMOVE_AT: begin
              if (count_q == '0) begin
                res_load     = 1'b1;
                res_status_d = ST_EMPTY;
              end else if (CNT_W'(pos) >= count_q) begin
                res_load     = 1'b1;
                res_status_d = ST_RANGE;
              end else begin
                mem_req_o.rd_en   = 1'b1;
                mem_req_o.rd_addr = IDX_W'(pos);
                k_d               = IDX_W'(pos);
                state_d           = S_TAKE;
              end
            end
            ACT_COUNT: begin
              res_load = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_INS: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = IDX_W'(k_q + 1'b1);
        if (rdata_i.prio > new_q.prio) begin
          // drop the new entry in behind the first higher priority
          mem_req_o.wr_data = new_q;
          count_d           = count_q + 1'b1;
          res_load          = 1'b1;
          state_d           = S_IDLE;
        end else begin
          mem_req_o.wr_data = rdata_i;
          if (k_q == '0) begin
            state_d = S_INSHEAD;
          end else begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = k_q - 1'b1;
            k_d               = k_q - 1'b1;
          end
        end
      end
      S_INSHEAD: begin
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = '0;
        mem_req_o.wr_data = new_q;
        count_d           = count_q + 1'b1;
        res_load          = 1'b1;
        state_d           = S_IDLE;
      end
      S_TAKE: begin
        taken_d = rdata_i.data;
        if (more) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = IDX_W'(k_q + 1'b1);
          k_d               = IDX_W'(k_q + 1'b1);
          state_d           = S_SHIFT;
        end else begin
          count_d    = count_q - 1'b1;
          res_load   = 1'b1;
          res_pv_d   = 1'b1;
          res_data_d = rdata_i.data;
          state_d    = S_IDLE;
        end
      end
      S_SHIFT: begin
        // close the gap one entry at a time
        mem_req_o.wr_en   = 1'b1;
        mem_req_o.wr_addr = k_q - 1'b1;
        mem_req_o.wr_data = rdata_i;
        if (more) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = IDX_W'(k_q + 1'b1);
          k_d               = IDX_W'(k_q + 1'b1);
        end else begin
          count_d    = count_q - 1'b1;
          res_load   = 1'b1;
          res_pv_d   = 1'b1;
          res_data_d = taken_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (res_load) begin
        ov_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    new_q   <= new_d;
    taken_q <= taken_d;
    if (res_load) begin
      res_data_q <= res_data_d;
      pv_q       <= res_pv_d;
      status_q   <= res_status_d;
      occ_q      <= OCC_WIDTH'(count_d);
    end
  end

  assign rsp_o.valid         = ov_q;
  assign rsp_o.payload_out   = res_data_q;
  assign rsp_o.payload_valid = pv_q;
  assign rsp_o.occupancy     = occ_q;
  assign rsp_o.status        = status_q;

  `SPQ_ASSERT_IMPL(a_busy_blocks, clk_i, rst_ni, state_q != S_IDLE, !ov_q && !req_i.ready)
  `SPQ_ASSERT_IMPL(a_payload_ok, clk_i, rst_ni, ov_q && pv_q, status_q == ST_OK)
  `SPQ_ASSERT_IMPL(a_ins_room, clk_i, rst_ni, state_q == S_INS,
                   count_q != '0 && count_q < CNT_W'(QUEUE_DEPTH))
  `SPQ_ASSERT_NEXT(a_shift_dec, clk_i, rst_ni, state_q == S_SHIFT && res_load,
                   count_q == $past(count_q) - 1'b1)

endmodule

FILE: verif/sorted_priority_queue_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Drives insert, removal and count requests through the request channel,
// predicts every response from a shadow copy of the sorted store and checks
// each response field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int CLK_HALF_NS = 6;
  localparam int RESET_CYCLES = 9;
  localparam int WATCHDOG_NS = 2_000_000;
  // Quiet time after the final drain, to catch any stray response.
  localparam int TAIL_CYCLES = 30;

  typedef struct packed {
    logic [1:0]            action;
    logic [DATA_WIDTH-1:0] payload;
    logic [PRIO_WIDTH-1:0] prio;
    logic [POS_WIDTH-1:0]  pos;
  } queue_op_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] payload;
    logic                  payload_valid;
    logic [OCC_WIDTH-1:0]  occupancy;
    logic [1:0]            status;
  } queue_resp_t;

  logic clk_i;
  logic rst_ni;

  spq_in_if  req_if ();
  spq_out_if rsp_if ();

  sorted_priority_queue_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the store, head at index 0, descending priority.
  logic [DATA_WIDTH-1:0] shadow_payload [QUEUE_DEPTH];
  logic [PRIO_WIDTH-1:0] shadow_prio    [QUEUE_DEPTH];
  int                    shadow_count;

  queue_resp_t pending_responses [$];
  queue_resp_t oldest_response;

  bit idle_enable;
  int mismatch_count;
  int items_sent;
  int action_seen [4];
  int status_seen [4];

  // --------------------------------------------------------------------------
  // Clock, reset and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  // Guard against a hung handshake; a correct run ends long before this.
  initial begin
    #(WATCHDOG_NS);
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction: apply one accepted item to the shadow store and return the
  // response it must produce. Insertion goes ahead of every entry with lower
  // or equal priority, so the newest wins a tie.
  // --------------------------------------------------------------------------
  function automatic queue_resp_t apply_queue_op(input queue_op_t op);
    queue_resp_t resp;
    int          slot;
    resp = '0;
    resp.status = ST_OK;
    case (op.action)
      ACT_INSERT: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          resp.status = ST_FULL;
        end else begin
          slot = 0;
          while (slot < shadow_count && shadow_prio[slot] > op.prio) slot++;
          for (int k = shadow_count; k > slot; k--) begin
            shadow_payload[k] = shadow_payload[k-1];
            shadow_prio[k]    = shadow_prio[k-1];
          end
          shadow_payload[slot] = op.payload;
          shadow_prio[slot]    = op.prio;
          shadow_count++;
        end
      end
      ACT_REMOVE_HEAD, ACT_REMOVE_AT: begin
        slot = (op.action == ACT_REMOVE_HEAD) ? 0 : int'(op.pos);
        if (shadow_count == 0) begin
          resp.status = ST_EMPTY;
        end else if (slot >= shadow_count) begin
          resp.status = ST_RANGE;
        end else begin
          resp.payload       = shadow_payload[slot];
          resp.payload_valid = 1'b1;
          for (int k = slot; k + 1 < shadow_count; k++) begin
            shadow_payload[k] = shadow_payload[k+1];
            shadow_prio[k]    = shadow_prio[k+1];
          end
          shadow_count--;
        end
      end
      default: begin
        // Count report: status ok, no payload.
      end
    endcase
    resp.occupancy = shadow_count[OCC_WIDTH-1:0];
    action_seen[op.action]++;
    status_seen[resp.status]++;
    return resp;
  endfunction

  // --------------------------------------------------------------------------
  // Send one item: optionally idle for a burst, then hold valid until the
  // item is taken, and queue the response it must cause.
  // --------------------------------------------------------------------------
  task automatic send_op(input logic [1:0] act, input logic [DATA_WIDTH-1:0] data,
                         input logic [PRIO_WIDTH-1:0] prio,
                         input logic [POS_WIDTH-1:0] pos);
    queue_op_t op;
    op.action  = act;
    op.payload = data;
    op.prio    = prio;
    op.pos     = pos;
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= op.action;
    req_if.payload_in   <= op.payload;
    req_if.priority_req <= op.prio;
    req_if.position     <= op.pos;
    do @(posedge clk_i); while (!req_if.ready);
    pending_responses.push_back(apply_queue_op(op));
    items_sent++;
  endtask

  // Drop valid and hold off until every queued response has come back.
  task automatic wait_responses_drained();
    req_if.valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Response side: random ready stalls, and the field-by-field check.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 5);
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_responses.size() == 0) begin
        $error("response with nothing outstanding: payload_out %0h status %0d",
               rsp_if.payload_out, rsp_if.status);
        mismatch_count++;
      end else begin
        oldest_response = pending_responses.pop_front();
        if (rsp_if.payload_out !== oldest_response.payload) begin
          $error("payload_out: expected %0h, got %0h",
                 oldest_response.payload, rsp_if.payload_out);
          mismatch_count++;
        end
        if (rsp_if.payload_valid !== oldest_response.payload_valid) begin
          $error("payload_valid: expected %0d, got %0d",
                 oldest_response.payload_valid, rsp_if.payload_valid);
          mismatch_count++;
        end
        if (rsp_if.occupancy !== oldest_response.occupancy) begin
          $error("occupancy: expected %0d, got %0d",
                 oldest_response.occupancy, rsp_if.occupancy);
          mismatch_count++;
        end
        if (rsp_if.status !== oldest_response.status) begin
          $error("status: expected %0d, got %0d",
                 oldest_response.status, rsp_if.status);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Removals and a count on an empty queue: empty status for the removals, no payload.
  task automatic test_empty_queue();
    send_op(ACT_REMOVE_HEAD, '1, '1, '0);
    send_op(ACT_REMOVE_AT, '0, '0, '1);
    send_op(ACT_COUNT, DATA_WIDTH'($urandom), PRIO_WIDTH'($urandom),
            POS_WIDTH'($urandom));
  endtask

  // Fill to the brim with extreme and tied priorities, then insert when full.
  task automatic test_fill_to_full();
    logic [PRIO_WIDTH-1:0] fill_prio [16] = '{
      8'd10, 8'd255, 8'd0, 8'd10, 8'd128, 8'd255, 8'd0, 8'd10,
      8'd64, 8'd200, 8'd1, 8'd254, 8'd10, 8'd127, 8'd0, 8'd255};
    logic [DATA_WIDTH-1:0] data;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      data = (i == 0) ? '0 : (i == 1) ? '1 : DATA_WIDTH'($urandom);
      send_op(ACT_INSERT, data, fill_prio[i], POS_WIDTH'($urandom));
    end
    send_op(ACT_INSERT, 16'hA5A5, 8'd255, '0);
    send_op(ACT_COUNT, '0, '0, '0);
  endtask

  // Indexed removal at the tail, beyond the tail, mid and head.
  task automatic test_remove_positions();
    send_op(ACT_REMOVE_AT, '0, '0, 4'd15);
    send_op(ACT_REMOVE_AT, '0, '0, 4'd15);
    send_op(ACT_REMOVE_AT, '0, '0, 4'd7);
    send_op(ACT_REMOVE_AT, '0, '0, 4'd0);
    send_op(ACT_REMOVE_HEAD, '0, '0, '0);
    send_op(ACT_COUNT, '1, '1, '1);
  endtask

  // Random actions; insert_pct steers the queue towards full or empty.
  task automatic run_random_ops(input int n_ops, input int insert_pct, input bit narrow_prio);
    logic [1:0]            act;
    logic [PRIO_WIDTH-1:0] prio;
    logic [POS_WIDTH-1:0]  pos;
    int                    pick;
    repeat (n_ops) begin
      pick = $urandom_range(0, 99);
      if (pick < insert_pct) begin
        act = ACT_INSERT;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40) act = ACT_REMOVE_HEAD;
        else if (pick < 85) act = ACT_REMOVE_AT;
        else act = ACT_COUNT;
      end
      // Narrow priorities force plenty of ties; otherwise favour the extremes.
      pick = $urandom_range(0, 7);
      if (narrow_prio) prio = PRIO_WIDTH'($urandom_range(0, 3));
      else if (pick == 0) prio = '0;
      else if (pick == 1) prio = '1;
      else prio = PRIO_WIDTH'($urandom);
      // Mostly a live position, sometimes anything the field can hold.
      if (shadow_count > 0 && $urandom_range(0, 9) != 0)
        pos = POS_WIDTH'($urandom_range(0, shadow_count - 1));
      else
        pos = POS_WIDTH'($urandom);
      send_op(act, DATA_WIDTH'($urandom), prio, pos);
    end
  endtask

  task automatic test_random_walk();
    run_random_ops(400, 50, 1'b0);
  endtask

  // Swing between full and empty, pausing until all responses are in.
  task automatic test_fill_drain_cycles();
    for (int round = 0; round < 5; round++) begin
      run_random_ops(30, 85, round[0]);
      run_random_ops(30, 15, round[0]);
      wait_responses_drained();
    end
  endtask

  // Back-to-back items and an always-ready receiver.
  task automatic test_back_to_back();
    idle_enable = 1'b0;
    run_random_ops(350, 55, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni              = 1'b0;
    idle_enable         = 1'b1;
    mismatch_count      = 0;
    items_sent          = 0;
    shadow_count        = 0;
    req_if.valid        <= 1'b0;
    req_if.action       <= ACT_COUNT;
    req_if.payload_in   <= '0;
    req_if.priority_req <= '0;
    req_if.position     <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_fill_to_full();
    test_remove_positions();
    test_random_walk();
    test_fill_drain_cycles();
    test_back_to_back();

    // Drain, then watch for stray responses.
    wait_responses_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Sent %0d items: %0d inserts, %0d head removals, %0d indexed removals, %0d counts",
             items_sent, action_seen[ACT_INSERT], action_seen[ACT_REMOVE_HEAD],
             action_seen[ACT_REMOVE_AT], action_seen[ACT_COUNT]);
    $display("Rejected: %0d when full, %0d when empty, %0d out of range",
             status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_RANGE]);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_if.sv
rtl/core/spq_store.sv
rtl/core/spq_ctrl.sv
rtl/core/sorted_priority_queue_unit.sv
verif/sorted_priority_queue_unit_tb.sv
